/* rtl/core/cweb_pkg.sv */
package cweb_pkg;

    // Sizes of the event store and the detector.
    localparam int BUFFER_DEPTH = 64;
    localparam int ROWS         = 5;

    // Field widths.
    localparam int TIME_W     = 48;
    localparam int CHARGE_W   = 16;
    localparam int ROW_W      = 3;
    localparam int WIDTH_W    = 32;
    localparam int HLIM_W     = 7;
    localparam int RLIM_W     = 3;
    localparam int CLASS_W    = 2;
    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Derived widths. The store has two banks so that one event can drain
    // while the next one fills.
    localparam int IDX_W     = $clog2(BUFFER_DEPTH);
    localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
    localparam int RAM_DEPTH = 2 * BUFFER_DEPTH;
    localparam int RAM_AW    = IDX_W + 1;
    localparam int ROWCMP_W  = 4;

    // Event descriptor queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT    = 2'd2;

    // Register reset values.
    localparam logic [WIDTH_W-1:0] WINDOW_WIDTH_RESET = 32'd2000000;
    localparam logic [HLIM_W-1:0]  HIT_LIMIT_RESET    = 7'd15;
    localparam logic [RLIM_W-1:0]  ROW_LIMIT_RESET    = 3'd4;

    // Event classes.
    localparam logic [CLASS_W-1:0] CLASS_LOW      = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_HIGH_SEL = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_HIGH_REJ = 2'd2;

    typedef struct packed {
        logic [WIDTH_W-1:0] window_width;
        logic [HLIM_W-1:0]  hit_limit;
        logic [RLIM_W-1:0]  row_limit;
    } cfg_t;

    // One closed event, waiting to be drained.
    typedef struct packed {
        logic               bank;
        logic [CNT_W-1:0]   size;
        logic [CLASS_W-1:0] cls;
        logic               dropped;
    } desc_t;

    // The back hands a bank back to the front.
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

    typedef struct packed {
        logic                en;
        logic [RAM_AW-1:0]   addr;
        logic [CHARGE_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
    } ram_rd_t;

endpackage

/* rtl/core/cweb_if.sv */
interface cweb_hit_if;
    import cweb_pkg::*;

    logic                valid;
    logic                ready;
    logic [TIME_W-1:0]   hit_time;
    logic [CHARGE_W-1:0] hit_charge;
    logic [ROW_W-1:0]    hit_row;

    modport source (output valid, hit_time, hit_charge, hit_row, input ready);
    modport sink   (input valid, hit_time, hit_charge, hit_row, output ready);
endinterface

interface cweb_res_if;
    import cweb_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHARGE_W-1:0] out_charge;
    logic [CLASS_W-1:0]  event_class;
    logic [SIZE_W-1:0]   event_size;
    logic                dropped_flag;
    logic                last_of_event;

    modport source (output valid, out_charge, event_class, event_size, dropped_flag,
                    last_of_event, input ready);
    modport sink   (input valid, out_charge, event_class, event_size, dropped_flag,
                    last_of_event, output ready);
endinterface

/* rtl/core/cweb_ram.sv */
module cweb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/cweb_queue.sv */
module cweb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cweb_pkg::desc_t push_desc,
    output logic            full,
    input  logic            pop,
    output cweb_pkg::desc_t head,
    output logic            empty
);
    import cweb_pkg::*;

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = wptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rptr_next = rptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Descriptor storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_desc;
        end
    end

endmodule

/* rtl/core/cweb_front.sv */
module cweb_front (
    input  logic              clk,
    input  logic              rst_n,
    cweb_hit_if.sink          hit,
    input  cweb_pkg::cfg_t    cfg,
    input  cweb_pkg::rel_t    rel,
    input  logic              q_full,
    output logic              q_push,
    output cweb_pkg::desc_t   q_desc,
    output cweb_pkg::ram_wr_t wr
);
    import cweb_pkg::*;

    // Held hit.
    logic                held_valid_reg, held_valid_next;
    logic [TIME_W-1:0]   held_time_reg;
    logic [CHARGE_W-1:0] held_charge_reg;
    logic [ROW_W-1:0]    held_row_reg;

    // Window state.
    logic                wopen_reg, wopen_next;
    logic [TIME_W-1:0]   start_reg, start_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ROWS-1:0]     rows_reg, rows_next;
    logic                ovf_reg, ovf_next;
    logic                bank_reg, bank_next;
    logic [1:0]          busy_reg, busy_next;

    logic [TIME_W-1:0]   delta;
    logic                in_win;
    logic                is_open;
    logic                is_close;
    logic                stall;
    logic                done;
    logic                room;
    logic [ROWS-1:0]     mark;
    logic [ROWCMP_W-1:0] rows_cnt;
    logic [CLASS_W-1:0]  cls;
    logic                accept;

    // Classify the held hit: open, store, or close the event.
    always_comb
    begin
        delta    = held_time_reg - start_reg;
        in_win   = (delta < TIME_W'(cfg.window_width));
        is_open  = !wopen_reg;
        is_close = wopen_reg && !in_win;
        stall    = is_close && (busy_reg[~bank_reg] || q_full);
        done     = held_valid_reg && !stall;
        room     = (count_reg < CNT_W'(BUFFER_DEPTH));
    end

    assign hit.ready = !held_valid_reg || done;
    assign accept    = hit.valid && hit.ready;

    // Row mask of the held hit and the number of rows hit so far.
    always_comb
    begin
        mark     = '0;
        rows_cnt = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            if (held_row_reg == ROW_W'(r))
            begin
                mark[r] = 1'b1;
            end
            rows_cnt = rows_cnt + ROWCMP_W'(rows_reg[r]);
        end
    end

    // Class of the event being closed.
    always_comb
    begin
        if (SIZE_W'(count_reg) > cfg.hit_limit)
        begin
            cls = (rows_cnt > ROWCMP_W'(cfg.row_limit)) ? CLASS_HIGH_SEL : CLASS_HIGH_REJ;
        end
        else
        begin
            cls = CLASS_LOW;
        end
    end

    assign q_push         = done && is_close;
    assign q_desc.bank    = bank_reg;
    assign q_desc.size    = count_reg;
    assign q_desc.cls     = cls;
    assign q_desc.dropped = ovf_reg;

    // Store write: slot zero of the new event's bank on open or close, else the next slot while there is room.
    always_comb
    begin
        wr.en   = done && (is_open || is_close || room);
        wr.data = held_charge_reg;
        if (is_open || is_close)
        begin
            wr.addr = {bank_next, IDX_W'(0)};
        end
        else
        begin
            wr.addr = {bank_reg, count_reg[IDX_W-1:0]};
        end
    end

    // Window and bank state update.
    always_comb
    begin
        wopen_next      = wopen_reg;
        start_next      = start_reg;
        count_next      = count_reg;
        rows_next       = rows_reg;
        ovf_next        = ovf_reg;
        bank_next       = bank_reg;
        busy_next       = busy_reg;
        held_valid_next = held_valid_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (is_close)
        begin
            bank_next = ~bank_reg;
        end
        if (done)
        begin
            held_valid_next = 1'b0;
            if (is_open || is_close)
            begin
                wopen_next = 1'b1;
                start_next = held_time_reg;
                count_next = CNT_W'(1);
                rows_next  = mark;
                ovf_next   = 1'b0;
                if (is_close)
                begin
                    busy_next[bank_reg] = 1'b1;
                end
            end
            else
            begin
                rows_next = rows_reg | mark;
                if (room)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end
        else
        begin
            bank_next = bank_reg;
        end
        if (accept)
        begin
            held_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            wopen_reg      <= 1'b0;
            start_reg      <= '0;
            count_reg      <= '0;
            rows_reg       <= '0;
            ovf_reg        <= 1'b0;
            bank_reg       <= 1'b0;
            busy_reg       <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            wopen_reg      <= wopen_next;
            start_reg      <= start_next;
            count_reg      <= count_next;
            rows_reg       <= rows_next;
            ovf_reg        <= ovf_next;
            bank_reg       <= bank_next;
            busy_reg       <= busy_next;
        end
    end

    // Hit payload capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_time_reg   <= hit.hit_time;
            held_charge_reg <= hit.hit_charge;
            held_row_reg    <= hit.hit_row;
        end
    end

endmodule

/* rtl/core/cweb_back.sv */
module cweb_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  cweb_pkg::desc_t               q_head,
    output logic                          q_pop,
    output cweb_pkg::ram_rd_t             rd,
    input  logic [cweb_pkg::CHARGE_W-1:0] rdata,
    output cweb_pkg::rel_t                rel,
    cweb_res_if.source                    res
);
    import cweb_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_FETCH = 3'b010,
        B_LOAD  = 3'b100
    } back_state_t;

    back_state_t         state_reg, state_next;
    desc_t               desc_reg;
    logic [IDX_W-1:0]    k_reg, k_next;

    logic                out_valid_reg, out_valid_next;
    logic [CHARGE_W-1:0] out_charge_reg;
    logic [CLASS_W-1:0]  out_class_reg;
    logic [SIZE_W-1:0]   out_size_reg;
    logic                out_dropped_reg;
    logic                out_last_reg;

    logic                out_free;
    logic                last;
    logic                load;

    assign out_free = !out_valid_reg || res.ready;
    assign last     = ((CNT_W'(k_reg) + CNT_W'(1)) == desc_reg.size);
    assign load     = (state_reg == B_LOAD) && out_free;

    assign q_pop     = (state_reg == B_IDLE) && !q_empty;
    assign rd.en     = (state_reg == B_FETCH);
    assign rd.addr   = {desc_reg.bank, k_reg};
    assign rel.valid = load && last;
    assign rel.bank  = desc_reg.bank;

    // Drain sequencer: read one stored charge, then move it to the output register.
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    k_next     = '0;
                    state_next = B_FETCH;
                end
            end
            B_FETCH:
            begin
                state_next = B_LOAD;
            end
            B_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = B_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Event descriptor and output payload.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            desc_reg <= q_head;
        end
        if (load)
        begin
            out_charge_reg  <= rdata;
            out_class_reg   <= desc_reg.cls;
            out_size_reg    <= SIZE_W'(desc_reg.size);
            out_dropped_reg <= desc_reg.dropped;
            out_last_reg    <= last;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.out_charge    = out_charge_reg;
    assign res.event_class   = out_class_reg;
    assign res.event_size    = out_size_reg;
    assign res.dropped_flag  = out_dropped_reg;
    assign res.last_of_event = out_last_reg;

endmodule

/* rtl/core/coincidence_window_event_builder_unit.sv */
// Channel   Direction  Payload
// hit       in         hit_time[47:0], hit_charge[15:0], hit_row[2:0]
// res       out        out_charge[15:0], event_class[1:0], event_size[6:0],
//                      dropped_flag, last_of_event
// cfg       in         cfg_we, cfg_index[1:0], cfg_wdata[31:0]
//
// A hit is taken into a holding register; a hit that closes an event also writes slot zero
// of the other store bank and waits while that bank still drains or the event queue is full.
// A closed event is first taken from the queue, then drained one charge at a time: each
// charge is read through the registered read of the charge store, then moved to the output register.
// Reset clears the window, bank and queue state and loads the register defaults.
// Either side may stall at any time; a two-entry event queue keeps them apart.
module coincidence_window_event_builder_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cweb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cweb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    cweb_hit_if.sink                        hit,
    cweb_res_if.source                      res
);
    import cweb_pkg::*;

    cfg_t                cfg_reg, cfg_next;
    rel_t                rel;
    desc_t               q_desc;
    desc_t               q_head;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    ram_wr_t             wr;
    ram_rd_t             rd;
    logic [CHARGE_W-1:0] rdata;

    // Configuration registers.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_WIDTH: cfg_next.window_width = cfg_wdata[WIDTH_W-1:0];
                REG_HIT_LIMIT:    cfg_next.hit_limit    = cfg_wdata[HLIM_W-1:0];
                REG_ROW_LIMIT:    cfg_next.row_limit    = cfg_wdata[RLIM_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_width <= WINDOW_WIDTH_RESET;
            cfg_reg.hit_limit    <= HIT_LIMIT_RESET;
            cfg_reg.row_limit    <= ROW_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: takes hits, tracks the window, fills the store.
    cweb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .hit    (hit),
        .cfg    (cfg_reg),
        .rel    (rel),
        .q_full (q_full),
        .q_push (q_push),
        .q_desc (q_desc),
        .wr     (wr)
    );

    // Closed events waiting to drain.
    cweb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_desc),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    // Two-bank charge store.
    cweb_ram #(
        .WIDTH (CHARGE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (rd.addr),
        .rdata (rdata)
    );

    // Back: drains one event at a time to the result channel.
    cweb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .rd      (rd),
        .rdata   (rdata),
        .rel     (rel),
        .res     (res)
    );

`ifndef SYNTHESIS
    // The front never fills a slot the back is reading.
    a_no_bank_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.en && rd.en) |-> (wr.addr != rd.addr))
        else $error("store write hits the slot being drained");

    // A closed event is only pushed when the queue has room.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("event pushed into a full queue");

    // The back only pops a present event.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("event popped from an empty queue");

    // A bank is released only as its final charge moves into a free output register.
    a_release_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        rel.valid |-> (!res.valid || res.ready))
        else $error("bank released while the output register is held");
`endif

endmodule

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cweb_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int RANDOM_ITEMS  = 270;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int PLAN_LEN      = 26;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic {STEP_HIT, STEP_CFG} step_kind_e;

    // One row of the directed plan. A configuration row carries its write data in stamp.
    // Where typed is set, the class and size of the results the hit causes are given here.
    typedef struct packed {
        step_kind_e           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [TIME_W-1:0]    stamp;
        logic [CHARGE_W-1:0]  charge;
        logic [ROW_W-1:0]     row;
        logic                 typed;
        logic [CLASS_W-1:0]   cls;
        logic [SIZE_W-1:0]    size;
    } step_t;

    // One charge drained from a closed event, with its tags.
    typedef struct packed {
        logic [CHARGE_W-1:0] charge;
        logic [CLASS_W-1:0]  cls;
        logic [SIZE_W-1:0]   size;
        logic                dropped;
        logic                last;
    } drained_hit_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cweb_hit_if hit_ch();
    cweb_res_if res_ch();

    coincidence_window_event_builder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .hit       (hit_ch),
        .res       (res_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Our own copy of the registers and of the window state.
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HLIM_W-1:0]   cfg_hit_limit;
    logic [RLIM_W-1:0]   cfg_row_limit;
    logic [TIME_W-1:0]   win_start;
    logic                win_open;
    int                  stored;
    logic [CHARGE_W-1:0] charge_mem [BUFFER_DEPTH];
    logic [ROWS-1:0]     rows_hit;
    logic                lost_hits;

    drained_hit_t      charges_due [$];
    int                mismatches   = 0;
    int                cycle_count  = 0;
    bit                no_idle      = 1'b0;
    int                stretch_left = 0;
    logic [TIME_W-1:0] last_stamp   = '0;

    // Directed plan: window edges, ignored rows, zero and full width, wrap and
    // backward time, the unused register index, and each event class.
    step_t plan [PLAN_LEN] = '{
        '{STEP_HIT, '0, 48'd0, 16'h0000, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_HIT, '0, 48'd1999999, 16'hFFFF, 3'd7, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_HIT, '0, 48'd2000000, 16'h8001, 3'd4, 1'b1, CLASS_LOW, 7'd2},
        '{STEP_CFG, REG_SPARE, 48'hDEAD_BEEF, 16'h0000, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_CFG, REG_HIT_LIMIT, 48'd0, 16'h0000, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_CFG, REG_ROW_LIMIT, 48'd0, 16'h0000, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_CFG, REG_WINDOW_WIDTH, 48'd0, 16'h0000, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_HIT, '0, 48'd2000000, 16'h0001, 3'd1, 1'b1, CLASS_HIGH_SEL, 7'd1},
        '{STEP_HIT, '0, 48'd2000000, 16'h0002, 3'd5, 1'b1, CLASS_HIGH_SEL, 7'd1},
        '{STEP_HIT, '0, 48'd2000001, 16'h0003, 3'd6, 1'b1, CLASS_HIGH_REJ, 7'd1},
        '{STEP_CFG, REG_WINDOW_WIDTH, 48'hFFFF_FFFF, 16'h0000, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_CFG, REG_HIT_LIMIT, 48'd64, 16'h0000, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_CFG, REG_ROW_LIMIT, 48'd5, 16'h0000, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_HIT, '0, 48'hFFFF_FFFF_FFFF, 16'h0004, 3'd2, 1'b1, CLASS_LOW, 7'd1},
        '{STEP_HIT, '0, 48'd0, 16'h0005, 3'd3, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_HIT, '0, 48'h0000_FFFF_FFFD, 16'h0006, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_HIT, '0, 48'h0000_FFFF_FFFE, 16'h0007, 3'd4, 1'b1, CLASS_LOW, 7'd3},
        '{STEP_HIT, '0, 48'h0000_0000_1234, 16'hA5A5, 3'd1, 1'b1, CLASS_LOW, 7'd1},
        '{STEP_CFG, REG_WINDOW_WIDTH, 48'd100, 16'h0000, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_CFG, REG_HIT_LIMIT, 48'd1, 16'h0000, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_CFG, REG_ROW_LIMIT, 48'd2, 16'h0000, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_HIT, '0, 48'h0000_0000_1297, 16'h5A5A, 3'd0, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_HIT, '0, 48'h0000_0000_1297, 16'h0F0F, 3'd2, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_HIT, '0, 48'h0000_0000_1298, 16'hF0F0, 3'd3, 1'b1, CLASS_HIGH_SEL, 7'd3},
        '{STEP_HIT, '0, 48'h0000_0000_12CA, 16'h3C3C, 3'd3, 1'b0, CLASS_LOW, 7'd0},
        '{STEP_HIT, '0, 48'h0000_0000_12FC, 16'hC3C3, 3'd0, 1'b1, CLASS_HIGH_REJ, 7'd2}
    };

    // Takes one accepted hit. A hit outside the open window closes the event and
    // queues one result per stored charge; then the hit is stored and its row marked.
    function automatic int window_hit(input logic [TIME_W-1:0] stamp,
                                      input logic [CHARGE_W-1:0] charge,
                                      input logic [ROW_W-1:0] row);
        logic [TIME_W-1:0]  delta;
        logic [CLASS_W-1:0] cls;
        int                 n;
        delta = stamp - win_start;
        n = 0;
        if (!(win_open && delta < cfg_width))
        begin
            n = win_open ? stored : 0;
            if (n > cfg_hit_limit)
                cls = ($countones(rows_hit) > cfg_row_limit) ? CLASS_HIGH_SEL : CLASS_HIGH_REJ;
            else
                cls = CLASS_LOW;
            for (int k = 0; k < n; k++)
                charges_due.push_back('{charge_mem[k], cls, SIZE_W'(n), lost_hits, k == n - 1});
            win_start = stamp;
            win_open  = 1'b1;
            rows_hit  = '0;
            lost_hits = 1'b0;
            stored    = 0;
        end
        if (stored < BUFFER_DEPTH)
        begin
            charge_mem[stored] = charge;
            stored++;
        end
        else
        begin
            lost_hits = 1'b1;
        end
        if (row < ROWS)
            rows_hit[row] = 1'b1;
        return n;
    endfunction

    task automatic report(input string what, input drained_hit_t got, input drained_hit_t want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s: got charge %h class %0d size %0d dropped %0b last %0b, expected %s",
                     what, got.charge, got.cls, got.size, got.dropped, got.last,
                     $sformatf("charge %h class %0d size %0d dropped %0b last %0b",
                               want.charge, want.cls, want.size, want.dropped, want.last));
    endtask

    // Let the hit channel fall idle, wait for every pending result, then let the
    // block finish its own work.
    task automatic settle(input int extra_cycles);
        @(negedge clk);
        hit_ch.valid <= 1'b0;
        while (charges_due.size() != 0)
            @(negedge clk);
        repeat (extra_cycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WINDOW_WIDTH: cfg_width     = data;
            REG_HIT_LIMIT:    cfg_hit_limit = data[HLIM_W-1:0];
            REG_ROW_LIMIT:    cfg_row_limit = data[RLIM_W-1:0];
            default:          ;
        endcase
    endtask

    // Offers one hit after a random gap and waits until it is taken. Stretches
    // without gaps on either side alternate with stretches full of them.
    task automatic drive_hit(input logic [TIME_W-1:0] stamp,
                             input logic [CHARGE_W-1:0] charge,
                             input logic [ROW_W-1:0] row,
                             output int made);
        int gap;
        if (stretch_left == 0)
        begin
            no_idle      = ($urandom_range(0, 2) == 0);
            stretch_left = $urandom_range(8, 40);
        end
        stretch_left--;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap != 0)
        begin
            hit_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        hit_ch.valid      <= 1'b1;
        hit_ch.hit_time   <= stamp;
        hit_ch.hit_charge <= charge;
        hit_ch.hit_row    <= row;
        @(posedge clk);
        while (!hit_ch.ready)
            @(posedge clk);
        last_stamp = stamp;
        made = window_hit(stamp, charge, row);
    endtask

    // Each accepted result is checked against the oldest pending one.
    always @(posedge clk)
    begin : res_check
        drained_hit_t got;
        got = '{res_ch.out_charge, res_ch.event_class, res_ch.event_size,
                res_ch.dropped_flag, res_ch.last_of_event};
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (charges_due.size() == 0)
                report("result with no event pending", got, '0);
            else if (got !== charges_due[0])
                report("result mismatch", got, charges_due.pop_front());
            else
                void'(charges_due.pop_front());
        end
    end

    // Result side drops ready for a random wait before taking each item, except in stretches without gaps.
    initial
    begin : res_drive
        int wait_cycles;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = no_idle ? 0 : $urandom_range(0, 19);
            if (wait_cycles != 0)
            begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
                repeat (wait_cycles - 1) @(negedge clk);
            end
            @(negedge clk);
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int                made;
        int                sent;
        int                phase_items;
        int                done;
        int                size;
        int                in_hits;
        int                pick;
        bit                forced;
        logic [TIME_W-1:0] offset;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] stamp;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        hit_ch.valid      = 1'b0;
        hit_ch.hit_time   = '0;
        hit_ch.hit_charge = '0;
        hit_ch.hit_row    = '0;

        cfg_width     = WINDOW_WIDTH_RESET;
        cfg_hit_limit = HIT_LIMIT_RESET;
        cfg_row_limit = ROW_LIMIT_RESET;
        win_start     = '0;
        win_open      = 1'b0;
        stored        = 0;
        rows_hit      = '0;
        lost_hits     = 1'b0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed plan; typed rows replace the predicted class and size.
        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_CFG)
            begin
                settle(SETTLE_CYCLES);
                write_reg(plan[i].reg_idx, plan[i].stamp[CFG_DATA_W-1:0]);
            end
            else
            begin
                drive_hit(plan[i].stamp, plan[i].charge, plan[i].row, made);
                if (plan[i].typed)
                    for (int k = charges_due.size() - made; k < charges_due.size(); k++)
                    begin
                        charges_due[k].cls     = plan[i].cls;
                        charges_due[k].size    = plan[i].size;
                        charges_due[k].dropped = 1'b0;
                    end
            end
        end

        // Random phases: new register settings, then mostly whole events with
        // random content, some with overflow, and a share of stray hits.
        sent   = 0;
        forced = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            settle(SETTLE_CYCLES);
            case ($urandom_range(0, 5))
                0:       write_reg(REG_WINDOW_WIDTH, 32'd1);
                1:       write_reg(REG_WINDOW_WIDTH, 32'hFFFF_FFFF);
                2:       write_reg(REG_WINDOW_WIDTH, 32'($urandom_range(2, 200)));
                3:       write_reg(REG_WINDOW_WIDTH, 32'($urandom_range(1000000, 3000000)));
                4:       write_reg(REG_WINDOW_WIDTH, 32'($urandom() | 1));
                default: write_reg(REG_WINDOW_WIDTH, 32'd100);
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(REG_HIT_LIMIT, 32'd0);
                1:       write_reg(REG_HIT_LIMIT, 32'd64);
                default: write_reg(REG_HIT_LIMIT, 32'($urandom_range(0, 20)));
            endcase
            write_reg(REG_ROW_LIMIT, 32'($urandom_range(0, 5)));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE, 32'($urandom()));

            phase_items = $urandom_range(30, 60);
            done = 0;
            while (done < phase_items)
            begin
                pick = $urandom_range(0, 99);
                if (!forced && pick < 10)
                begin
                    // A stray hit anywhere in time, often backwards.
                    drive_hit(TIME_W'({$urandom(), $urandom()}),
                              CHARGE_W'($urandom_range(0, 65535)),
                              ROW_W'($urandom_range(0, 7)), made);
                    done++;
                end
                else
                begin
                    if (forced)
                        size = $urandom_range(66, 72);
                    else if (pick < 13)
                        size = $urandom_range(60, 72);
                    else if (pick < 40)
                        size = int'(cfg_hit_limit) + int'($urandom_range(0, 4)) - 2;
                    else
                        size = $urandom_range(1, 10);
                    if (size < 1)
                        size = 1;
                    forced = 1'b0;

                    // Hits inside the window, spread out and now and then on its last tick.
                    in_hits = (size > stored) ? size - stored : 0;
                    offset = last_stamp - win_start;
                    for (int j = 0; j < in_hits; j++)
                    begin
                        if (offset < cfg_width)
                        begin
                            span = cfg_width - 1 - offset;
                            per  = span / (in_hits - j + 1);
                            if ($urandom_range(0, 9) == 0)
                                offset = cfg_width - 1;
                            else
                                offset = offset + $urandom_range(per[31:0], 0);
                        end
                        drive_hit(win_start + offset, CHARGE_W'($urandom_range(0, 65535)),
                                  ROW_W'($urandom_range(0, 7)), made);
                    end

                    // The hit that closes the event, sometimes exactly on the window end.
                    stamp = win_start + cfg_width;
                    if ($urandom_range(0, 3) != 0)
                        stamp = stamp + $urandom_range(0, 5000);
                    drive_hit(stamp, CHARGE_W'($urandom_range(0, 65535)),
                              ROW_W'($urandom_range(0, 7)), made);
                    done += in_hits + 1;
                end
            end
            sent += done;
        end

        settle(TAIL_CYCLES);
        if (mismatches == 0 && charges_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
